// ----- hdl/tpld_pkg.sv -----
// Shared types and codes for the two-phase line debouncer.
`default_nettype none

package tpld_pkg;

  localparam int REG_W = 16;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_BLANK  = 2'd1,
    MODE_WATCH  = 2'd2,
    MODE_STABLE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_UNKNOWN = 2'd0,
    ST_LOW     = 2'd1,
    ST_HIGH    = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFF_TICKS   = 1'd0,
    CFG_QUIET_TICKS = 1'd1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       line_level;
  } cmd_t;

  typedef struct packed {
    status_t line_status;
    logic    notify;
    mode_t   mode_now;
  } rsp_t;

  typedef struct packed {
    cfg_index_t        index;
    logic [REG_W-1:0]  data;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/tpld_cmd_if.sv -----
// Command channel: opcode and raw line level, valid/ready handshake.
`default_nettype none

interface tpld_cmd_if;
  import tpld_pkg::*;

  logic valid;
  logic ready;
  cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/tpld_rsp_if.sv -----
// Result channel: status, notify and mode, valid/ready handshake.
`default_nettype none

interface tpld_rsp_if;
  import tpld_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/tpld_cfg_if.sv -----
// Configuration write channel: register index and data, valid/ready handshake.
`default_nettype none

interface tpld_cfg_if;
  import tpld_pkg::*;

  logic valid;
  logic ready;
  cfg_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/two_phase_line_debouncer.sv -----
// Top level of the two-phase line debouncer: mode sequencer and result buffer.
//
// Usage:
//   cmd  - one item per tick, start or stop command, with the raw line level.
//   rsp  - exactly one result item per command item: line_status, notify and
//          mode_now after that command.
//   cfg  - register writes (index 0 off_ticks, index 1 quiet_ticks), always
//          ready; write only while the block is idle.
// Throughput: one item per cycle while the skid register is empty; the
// mode/count update is a single compare-and-decrement between the state
// registers, so back-to-back items run at full rate unless rsp stalls.
// Stalls: results sit in an output register backed by a one-entry skid
// register; cmd.ready drops only when both are full, and no item is lost.
// Reset: mode idle, status unknown, count and sampled level zero, both
// period registers one, result buffer empty.
`default_nettype none

module two_phase_line_debouncer #(
  parameter int COUNT_WIDTH = 16
) (
  input wire logic clk,
  input wire logic rst,
  tpld_cmd_if.sink   cmd,
  tpld_rsp_if.source rsp,
  tpld_cfg_if.sink   cfg
);
  import tpld_pkg::*;

  // Period registers
  logic [REG_W-1:0] off_ticks;
  logic [REG_W-1:0] quiet_ticks;

  // Debounce state
  mode_t                  mode, mode_next;
  status_t                status_reg, status_next;
  logic [COUNT_WIDTH-1:0] tick_count, count_next;
  logic                   sampled_level, sampled_next;
  logic                   notify_c;

  // Result buffer: output register plus skid register
  rsp_t out_data;
  logic out_valid;
  rsp_t skid_data;
  logic skid_valid;

  logic cmd_acc;
  logic out_fire;
  logic lvl_change;
  logic count_le1;
  logic [COUNT_WIDTH-1:0] load_off;
  logic [COUNT_WIDTH-1:0] load_quiet;
  rsp_t res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_ticks   <= REG_W'(1);
      quiet_ticks <= REG_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.payload.index)
        CFG_OFF_TICKS:   off_ticks   <= cfg.payload.data;
        CFG_QUIET_TICKS: quiet_ticks <= cfg.payload.data;
        default: ;
      endcase
    end
  end

  // Loaded periods saturate when the counter is narrower than the register.
  generate
    if (COUNT_WIDTH >= REG_W) begin : g_wide
      assign load_off   = COUNT_WIDTH'(off_ticks);
      assign load_quiet = COUNT_WIDTH'(quiet_ticks);
    end else begin : g_narrow
      assign load_off   = (|off_ticks[REG_W-1:COUNT_WIDTH]) ? '1
                                                            : off_ticks[COUNT_WIDTH-1:0];
      assign load_quiet = (|quiet_ticks[REG_W-1:COUNT_WIDTH]) ? '1
                                                              : quiet_ticks[COUNT_WIDTH-1:0];
    end
  endgenerate

  assign cmd.ready = !skid_valid;
  assign cmd_acc   = cmd.valid && !skid_valid;
  assign out_fire  = out_valid && rsp.ready;

  // A count of zero or one means this tick ends the phase.
  assign count_le1  = (tick_count[COUNT_WIDTH-1:1] == '0);
  assign lvl_change = ((mode == MODE_WATCH) || (mode == MODE_STABLE)) &&
                      (cmd.payload.line_level != sampled_level);

  // Next state: stop beats a change of level, which beats a timeout.
  always_comb begin
    mode_next    = mode;
    status_next  = status_reg;
    count_next   = tick_count;
    sampled_next = sampled_level;
    notify_c     = 1'b0;
    if (cmd.payload.opcode == OP_STOP) begin
      mode_next   = MODE_IDLE;
      status_next = ST_UNKNOWN;
      count_next  = '0;
    end else if (mode == MODE_IDLE) begin
      if (cmd.payload.opcode == OP_START) begin
        mode_next   = MODE_BLANK;
        status_next = ST_UNKNOWN;
        count_next  = load_off;
      end
    end else if (lvl_change) begin
      mode_next   = MODE_BLANK;
      status_next = ST_UNKNOWN;
      count_next  = load_off;
    end else if ((cmd.payload.opcode == OP_TICK) && (mode != MODE_STABLE)) begin
      if (count_le1) begin
        if (mode == MODE_BLANK) begin
          mode_next    = MODE_WATCH;
          sampled_next = cmd.payload.line_level;
          status_next  = cmd.payload.line_level ? ST_HIGH : ST_LOW;
          count_next   = load_quiet;
        end else begin
          mode_next  = MODE_STABLE;
          count_next = '0;
          notify_c   = 1'b1;
        end
      end else begin
        count_next = tick_count - COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      status_reg    <= ST_UNKNOWN;
      tick_count    <= '0;
      sampled_level <= 1'b0;
    end else if (cmd_acc) begin
      mode          <= mode_next;
      status_reg    <= status_next;
      tick_count    <= count_next;
      sampled_level <= sampled_next;
    end
  end

  always_comb begin
    res.line_status = status_next;
    res.notify      = notify_c;
    res.mode_now    = mode_next;
  end

  // Result buffer; the skid register only fills when the output is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (cmd_acc) begin
      if (!out_valid || out_fire) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  // Checks
  a_notify_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.notify) |-> (out_data.mode_now == MODE_STABLE))
    else $error("notify raised outside stable");

  a_status_mode: assert property (@(posedge clk) disable iff (rst)
    ((mode == MODE_IDLE) || (mode == MODE_BLANK)) == (status_reg == ST_UNKNOWN))
    else $error("status does not match mode");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while output is empty");

  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && (cmd.payload.opcode == OP_STOP)) |=> (mode == MODE_IDLE))
    else $error("stop did not return to idle");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the two-phase line debouncer.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tpld_pkg::*;

  // Count width of the instance; period registers saturate to this when loaded.
  localparam int CNT_W = 16;
  // Opcode 3 has no enum member: it is "no command", but the level check applies.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  // One row of the directed walk. Where has_want is set, the result is typed in
  // by hand; otherwise the row is checked against the predictor.
  typedef struct packed {
    logic [1:0] op;
    logic       lvl;
    logic       has_want;
    rsp_t       want;
  } dir_row_t;

  // Register setting for one random phase, and how many items it runs.
  typedef struct packed {
    logic [REG_W-1:0] off;
    logic [REG_W-1:0] quiet;
    logic [15:0]      n_items;
  } phase_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_ONE_IN_FOUR,
    STALL_EVERY_THIRD
  } stall_style_t;

  localparam rsp_t NO_WANT = '{ST_UNKNOWN, 1'b0, MODE_IDLE};

  // Walked with both periods at their reset value of one tick.
  localparam int N_DIR = 21;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // idle ignores ticks, level and the unused opcode
    '{OP_TICK,   1'b0, 1'b1, '{ST_UNKNOWN, 1'b0, MODE_IDLE}},
    '{OP_TICK,   1'b1, 1'b1, '{ST_UNKNOWN, 1'b0, MODE_IDLE}},
    '{OP_UNUSED, 1'b1, 1'b1, '{ST_UNKNOWN, 1'b0, MODE_IDLE}},
    '{OP_STOP,   1'b0, 1'b1, '{ST_UNKNOWN, 1'b0, MODE_IDLE}},
    // start, then a second start and a command-free item inside blanking
    '{OP_START,  1'b1, 1'b1, '{ST_UNKNOWN, 1'b0, MODE_BLANK}},
    '{OP_START,  1'b0, 1'b1, '{ST_UNKNOWN, 1'b0, MODE_BLANK}},
    '{OP_UNUSED, 1'b1, 1'b1, '{ST_UNKNOWN, 1'b0, MODE_BLANK}},
    // blanking ends: sample high
    '{OP_TICK,   1'b1, 1'b1, '{ST_HIGH,    1'b0, MODE_WATCH}},
    '{OP_START,  1'b1, 1'b0, NO_WANT},
    '{OP_TICK,   1'b1, 1'b1, '{ST_HIGH,    1'b1, MODE_STABLE}},
    '{OP_TICK,   1'b1, 1'b0, NO_WANT},
    // level drop on a non-tick item in stable
    '{OP_UNUSED, 1'b0, 1'b0, NO_WANT},
    '{OP_TICK,   1'b0, 1'b0, NO_WANT},
    // level change on a start while watching
    '{OP_START,  1'b1, 1'b0, NO_WANT},
    '{OP_TICK,   1'b0, 1'b0, NO_WANT},
    '{OP_TICK,   1'b0, 1'b0, NO_WANT},
    // stop wins over a level change
    '{OP_STOP,   1'b1, 1'b1, '{ST_UNKNOWN, 1'b0, MODE_IDLE}},
    '{OP_START,  1'b0, 1'b1, '{ST_UNKNOWN, 1'b0, MODE_BLANK}},
    '{OP_TICK,   1'b0, 1'b0, NO_WANT},
    // level change wins over the timeout on the same tick
    '{OP_TICK,   1'b1, 1'b0, NO_WANT},
    '{OP_STOP,   1'b0, 1'b1, '{ST_UNKNOWN, 1'b0, MODE_IDLE}}
  };

  // Zero periods, the reset value, small odd values and the full range.
  localparam int N_PHASES = 8;
  localparam phase_t PHASES [N_PHASES] = '{
    '{16'd0,     16'd0,     16'd100},
    '{16'd1,     16'd1,     16'd100},
    '{16'd2,     16'd3,     16'd110},
    '{16'hFFFF,  16'hFFFF,  16'd25},
    '{16'd5,     16'd2,     16'd100},
    '{16'd1,     16'hFFFF,  16'd25},
    '{16'd3,     16'd0,     16'd100},
    '{16'd0,     16'd6,     16'd90}
  };

  logic clk = 1'b0;
  logic rst;

  tpld_cmd_if cmd_ch ();
  tpld_rsp_if rsp_ch ();
  tpld_cfg_if cfg_ch ();

  two_phase_line_debouncer #(.COUNT_WIDTH(CNT_W)) uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #5ns clk = ~clk;

  // Predicted debouncer state and its own copy of the period registers.
  mode_t            pr_mode;
  logic [CNT_W-1:0] pr_count;
  status_t          pr_status;
  logic             pr_sample;
  logic [REG_W-1:0] pr_off;
  logic [REG_W-1:0] pr_quiet;

  rsp_t pending_status_q [$];   // results owed by the block, oldest first
  int   n_errors = 0;
  int   n_cycles = 0;
  int   burst_left = 0;
  logic line_now = 1'b0;        // raw line level fed to the random part

  // Period registers saturate to the counter range when loaded.
  function automatic logic [CNT_W-1:0] clamp_period(input logic [REG_W-1:0] v);
    longint unsigned top;
    top = (longint'(1) << CNT_W) - 1;
    if (longint'(v) > top)
      return CNT_W'(top);
    return CNT_W'(v);
  endfunction

  function automatic void enter_blanking();
    pr_mode   = MODE_BLANK;
    pr_status = ST_UNKNOWN;
    pr_count  = clamp_period(pr_off);
  endfunction

  // Advance the predicted state by one item and return the result it causes.
  // Order of precedence: stop, then level change, then timeout.
  function automatic rsp_t debounce_step(input logic [1:0] op, input logic lvl);
    rsp_t r;
    logic fired;
    fired = 1'b0;
    if (op == OP_STOP) begin
      // sampled level is kept across a stop
      pr_mode   = MODE_IDLE;
      pr_status = ST_UNKNOWN;
      pr_count  = '0;
    end else if (pr_mode == MODE_IDLE) begin
      if (op == OP_START)
        enter_blanking();
    end else if ((pr_mode == MODE_WATCH || pr_mode == MODE_STABLE) && lvl != pr_sample) begin
      enter_blanking();
    end else if (op == OP_TICK && pr_mode != MODE_STABLE) begin
      // a count of 0 or 1 times out on this tick
      if (pr_count <= CNT_W'(1)) begin
        if (pr_mode == MODE_BLANK) begin
          pr_mode   = MODE_WATCH;
          pr_sample = lvl;
          pr_status = lvl ? ST_HIGH : ST_LOW;
          pr_count  = clamp_period(pr_quiet);
        end else begin
          pr_mode  = MODE_STABLE;
          pr_count = '0;
          fired    = 1'b1;
        end
      end else begin
        pr_count = pr_count - CNT_W'(1);
      end
    end
    r.line_status = pr_status;
    r.notify      = fired;
    r.mode_now    = pr_mode;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("%0t ERROR %s", $realtime, msg);
  endtask

  // Called at a falling edge before each item: ends a burst with a random
  // gap, possibly none, and now and then waits for every owed result.
  task automatic pace();
    int  gap;
    bit  drain;
    if (burst_left == 0) begin
      gap   = $urandom_range(0, 5);
      drain = ($urandom_range(0, 39) == 0);
      if (gap != 0 || drain) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
        if (drain)
          do @(negedge clk); while (pending_status_q.size() != 0);
      end
      // mostly short bursts, sometimes a long run with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Present one item at a falling edge, hold it until taken, then predict.
  task automatic send_cmd(input logic [1:0] op, input logic lvl,
                          input logic has_want, input rsp_t want);
    rsp_t predicted;
    pace();
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= '{opcode: op, line_level: lvl};
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predicted = debounce_step(op, lvl);
    pending_status_q.push_back(has_want ? want : predicted);
    @(negedge clk);
  endtask

  // Drop valid and wait until all results are in, then let the block settle.
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write; leaves valid high so a following write needs no re-raise.
  task automatic write_reg(input cfg_index_t idx, input logic [REG_W-1:0] value);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{index: idx, data: value};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_OFF_TICKS)
      pr_off = value;
    else
      pr_quiet = value;
    @(negedge clk);
  endtask

  // Random items: mostly start-then-tick sequences on a slowly moving line,
  // with stray commands, stops and the unused opcode as noise.
  task automatic run_random(input int n_items);
    int         pick;
    logic [1:0] op;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pr_mode == MODE_IDLE) begin
        if (pick < 65)      op = OP_START;
        else if (pick < 85) op = OP_TICK;
        else if (pick < 95) op = OP_UNUSED;
        else                op = OP_STOP;
      end else begin
        if (pick < 80)      op = OP_TICK;
        else if (pick < 87) op = OP_START;
        else if (pick < 93) op = OP_UNUSED;
        else                op = OP_STOP;
      end
      // occasional bounce of the raw line
      if ($urandom_range(0, 11) == 0)
        line_now = ~line_now;
      send_cmd(op, line_now, 1'b0, NO_WANT);
    end
  endtask

  // Result side: a stall pattern on ready that is redrawn at random.
  stall_style_t stall_style = STALL_NONE;
  int           stall_tick = 0;

  always @(negedge clk) begin
    if (stall_tick % 64 == 0)
      stall_style = stall_style_t'($urandom_range(0, 3));
    stall_tick++;
    case (stall_style)
      STALL_NONE:        rsp_ch.ready <= 1'b1;
      STALL_COIN:        rsp_ch.ready <= 1'($urandom_range(0, 1));
      STALL_ONE_IN_FOUR: rsp_ch.ready <= (stall_tick % 4 == 0);
      default:           rsp_ch.ready <= (stall_tick % 3 != 0);
    endcase
  end

  // Every result taken is matched against the oldest owed one.
  always @(posedge clk) begin : check_rsp
    rsp_t got;
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.payload;
      if (pending_status_q.size() == 0) begin
        flag_error($sformatf("unexpected result status=%0d notify=%0d mode=%0d",
                             got.line_status, got.notify, got.mode_now));
      end else begin
        want = pending_status_q.pop_front();
        if (got.line_status != want.line_status || got.notify != want.notify ||
            got.mode_now != want.mode_now)
          flag_error($sformatf(
            "result mismatch: status exp %0d got %0d, notify exp %0d got %0d, mode exp %0d got %0d",
            want.line_status, got.line_status, want.notify, got.notify,
            want.mode_now, got.mode_now));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    rsp_ch.ready   = 1'b0;

    // predictor at its reset state
    pr_mode   = MODE_IDLE;
    pr_count  = '0;
    pr_status = ST_UNKNOWN;
    pr_sample = 1'b0;
    pr_off    = 16'd1;
    pr_quiet  = 16'd1;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed walk at the reset periods
    for (int i = 0; i < N_DIR; i++)
      send_cmd(DIR_ROWS[i].op, DIR_ROWS[i].lvl, DIR_ROWS[i].has_want, DIR_ROWS[i].want);

    // random phases, each behind a fresh register setting written while idle
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      write_reg(CFG_OFF_TICKS, PHASES[p].off);
      write_reg(CFG_QUIET_TICKS, PHASES[p].quiet);
      cfg_ch.valid <= 1'b0;
      @(negedge clk);
      run_random(int'(PHASES[p].n_items));
    end

    // drain and allow time for anything stray to show up
    wait_idle();
    repeat (6) @(negedge clk);

    if (n_errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
